FILE: sv/pmg_pkg.sv
// shared types, constants and level transform for the peano meander point generator
package pmg_pkg;

	localparam int MAX_DEGREE = 8;
	localparam int DIGIT_W    = 4;
	localparam int CTR_W      = MAX_DEGREE * DIGIT_W;
	localparam int COORD_W    = 13;
	localparam int INDEX_W    = 26;
	localparam int DEGREE_W   = 4;
	localparam int NUM_STG    = MAX_DEGREE;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [DIGIT_W-1:0] TOP_DIGIT  = 4'd8;
	localparam logic [DIGIT_W-1:0] NOOP_DIGIT = 4'd15;
	localparam logic [DEGREE_W-1:0] DEGREE_RESET = 4'd2;
	localparam logic [DEGREE_W-1:0] DEGREE_MIN   = 4'd1;
	localparam logic [DEGREE_W-1:0] DEGREE_MAX   = DEGREE_W'(MAX_DEGREE);

	// level transform codes, one per base-9 digit value
	localparam logic [DIGIT_W-1:0] OP_SWAP        = 4'd0;
	localparam logic [DIGIT_W-1:0] OP_SWAP_RIGHT  = 4'd1;
	localparam logic [DIGIT_W-1:0] OP_UP2         = 4'd2;
	localparam logic [DIGIT_W-1:0] OP_RIGHT_UP2   = 4'd3;
	localparam logic [DIGIT_W-1:0] OP_RIGHT2_UP2  = 4'd4;
	localparam logic [DIGIT_W-1:0] OP_MIRROR      = 4'd5;
	localparam logic [DIGIT_W-1:0] OP_MIRROR_SWAP = 4'd6;
	localparam logic [DIGIT_W-1:0] OP_FOLD_SWAP   = 4'd7;
	localparam logic [DIGIT_W-1:0] OP_RIGHT2      = 4'd8;

	// base 3x3 meander cell positions
	localparam logic [1:0] CELL_COL [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd2};
	localparam logic [1:0] CELL_ROW [9] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0};

	// sub-square side at each level, three to the power of the level
	localparam logic [COORD_W-1:0] LEVEL_LEN [MAX_DEGREE] = '{
		13'd1, 13'd3, 13'd9, 13'd27, 13'd81, 13'd243, 13'd729, 13'd2187
	};

	typedef struct packed {
		logic [CTR_W-1:0]   digits;
		logic [INDEX_W-1:0] index;
		logic               last;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} point_t;

	// one level of the curve: swap, offset or reflect by the level digit
	function automatic point_t apply_level(input point_t p, input logic [DIGIT_W-1:0] dig,
		input logic [COORD_W-1:0] len);
		logic [COORD_W-1:0] len2;
		logic [COORD_W-1:0] len3;
		point_t r;
		len2 = len << 1;
		len3 = len2 + len;
		r = p;
		case (dig)
			OP_SWAP: begin
				r.x = p.y;
				r.y = p.x;
			end
			OP_SWAP_RIGHT: begin
				r.x = p.y;
				r.y = p.x + len;
			end
			OP_UP2: begin
				r.y = p.y + len2;
			end
			OP_RIGHT_UP2: begin
				r.x = p.x + len;
				r.y = p.y + len2;
			end
			OP_RIGHT2_UP2: begin
				r.x = p.x + len2;
				r.y = p.y + len2;
			end
			OP_MIRROR: begin
				r.x = len3 - 13'd1 - p.x;
				r.y = len2 - 13'd1 - p.y;
			end
			OP_MIRROR_SWAP: begin
				r.x = len2 - 13'd1 - p.y;
				r.y = len2 - 13'd1 - p.x;
			end
			OP_FOLD_SWAP: begin
				r.x = len2 - 13'd1 - p.y;
				r.y = len - 13'd1 - p.x;
			end
			OP_RIGHT2: begin
				r.x = p.x + len2;
			end
			default: begin
				r = p;
			end
		endcase
		return r;
	endfunction

endpackage

FILE: sv/pmg_front.sv
// front part: takes ticks, keeps the walk counter and classifies each point
module pmg_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [pmg_pkg::DEGREE_W-1:0]    degree,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,    // [0] restart, rest zero
	input  logic                            q_not_full,
	output logic                            q_push,
	output pmg_pkg::item_t                  q_item
);

	logic [pmg_pkg::CTR_W-1:0]   digit_counter_q;
	logic [pmg_pkg::INDEX_W-1:0] linear_count_q;

	logic [pmg_pkg::DEGREE_W-1:0] d_eff;
	logic [pmg_pkg::CTR_W-1:0]    cur_dig;
	logic [pmg_pkg::INDEX_W-1:0]  cur_idx;
	logic [pmg_pkg::CTR_W-1:0]    next_dig;
	logic [pmg_pkg::CTR_W-1:0]    masked_dig;
	logic [pmg_pkg::MAX_DEGREE-1:0] in_use;
	logic [pmg_pkg::MAX_DEGREE-1:0] at_top;
	logic                         is_last;
	logic                         carry;
	logic                         restart;

	assign restart  = s_tdata[0];
	assign s_tready = q_not_full;
	assign q_push   = s_tvalid && s_tready;

	// clamp degree into the supported range
	always_comb begin
		if (degree < pmg_pkg::DEGREE_MIN) begin
			d_eff = pmg_pkg::DEGREE_MIN;
		end else if (degree > pmg_pkg::DEGREE_MAX) begin
			d_eff = pmg_pkg::DEGREE_MAX;
		end else begin
			d_eff = degree;
		end
	end

	// current position, last flag and next counter value
	always_comb begin
		cur_dig    = restart ? '0 : digit_counter_q;
		cur_idx    = restart ? '0 : linear_count_q;
		next_dig   = cur_dig;
		masked_dig = cur_dig;
		carry      = 1'b1;
		for (int k = 0; k < pmg_pkg::MAX_DEGREE; k++) begin
			in_use[k] = (pmg_pkg::DEGREE_W'(k) < d_eff);
			at_top[k] = (cur_dig[k*pmg_pkg::DIGIT_W +: pmg_pkg::DIGIT_W] >= pmg_pkg::TOP_DIGIT);
			if (!in_use[k]) begin
				masked_dig[k*pmg_pkg::DIGIT_W +: pmg_pkg::DIGIT_W] = pmg_pkg::NOOP_DIGIT;
			end
			if (in_use[k] && carry) begin
				if (at_top[k]) begin
					next_dig[k*pmg_pkg::DIGIT_W +: pmg_pkg::DIGIT_W] = '0;
				end else begin
					next_dig[k*pmg_pkg::DIGIT_W +: pmg_pkg::DIGIT_W] =
						cur_dig[k*pmg_pkg::DIGIT_W +: pmg_pkg::DIGIT_W] + 4'd1;
					carry = 1'b0;
				end
			end
		end
		is_last = &(at_top | ~in_use);
	end

	assign q_item.digits = masked_dig;
	assign q_item.index  = cur_idx;
	assign q_item.last   = is_last;

	// walk counter advances on every transfer, wrapping after the final point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_counter_q <= '0;
			linear_count_q  <= '0;
		end else if (q_push) begin
			if (is_last) begin
				digit_counter_q <= '0;
				linear_count_q  <= '0;
			end else begin
				digit_counter_q <= next_dig;
				linear_count_q  <= cur_idx + 26'd1;
			end
		end
	end

	a_wrap_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && is_last) |=> (digit_counter_q == '0 && linear_count_q == '0))
		else $error("counter not cleared after final point");

	a_restart_index: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && restart) |-> (q_item.index == '0))
		else $error("restart did not zero the point index");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !is_last) |=> (linear_count_q == $past(cur_idx) + 26'd1))
		else $error("point index did not advance by one");

endmodule

FILE: sv/pmg_queue.sv
// short queue of classified points between front and back
module pmg_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pmg_pkg::item_t  push_item,
	output logic            not_full,
	output logic            pop_valid,
	input  logic            pop,
	output pmg_pkg::item_t  pop_item
);

	pmg_pkg::item_t              entry_q [pmg_pkg::QUEUE_DEPTH];
	logic [pmg_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [pmg_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [pmg_pkg::QCNT_W-1:0]  count_q;
	logic                        do_push;
	logic                        do_pop;

	assign not_full  = (count_q != pmg_pkg::QCNT_W'(pmg_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = entry_q[rd_ptr_q];
	assign do_push   = push && not_full;
	assign do_pop    = pop && pop_valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/pmg_back.sv
// back part: one pipeline stage per curve level turns digits into coordinates
module pmg_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  pmg_pkg::item_t  q_item,
	output logic            q_pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [55:0]     m_tdata,    // [12:0] x_coord, [25:13] y_coord,
	                                    // [51:26] point_index, rest zero
	output logic            m_tlast
);

	localparam int LAST_STG = pmg_pkg::NUM_STG - 1;

	// stage registers, index is the stage number
	logic                          vld_s   [pmg_pkg::NUM_STG];
	pmg_pkg::point_t               pt_s    [pmg_pkg::NUM_STG];
	logic [pmg_pkg::CTR_W-1:0]     dig_s   [pmg_pkg::NUM_STG];
	logic [pmg_pkg::INDEX_W-1:0]   idx_s   [pmg_pkg::NUM_STG];
	logic                          last_s  [pmg_pkg::NUM_STG];

	logic                          advance;
	logic [pmg_pkg::DIGIT_W-1:0]   dig0;
	pmg_pkg::point_t               base_pt;

	assign advance = !vld_s[LAST_STG] || m_tready;
	assign q_pop   = advance && q_valid;

	// base cell from the lowest digit
	always_comb begin
		dig0 = q_item.digits[pmg_pkg::DIGIT_W-1:0];
		if (dig0 <= pmg_pkg::TOP_DIGIT) begin
			base_pt.x = pmg_pkg::COORD_W'(pmg_pkg::CELL_COL[dig0]);
			base_pt.y = pmg_pkg::COORD_W'(pmg_pkg::CELL_ROW[dig0]);
		end else begin
			base_pt = '0;
		end
	end

	// stage zero valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (advance) begin
			vld_s[0] <= q_valid;
		end
	end

	// stage zero payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			pt_s[0]   <= base_pt;
			dig_s[0]  <= q_item.digits;
			idx_s[0]  <= q_item.index;
			last_s[0] <= q_item.last;
		end
	end

	// level stages
	for (genvar j = 1; j < pmg_pkg::NUM_STG; j++) begin : g_level
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (advance) begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (advance && vld_s[j-1]) begin
				pt_s[j]   <= pmg_pkg::apply_level(pt_s[j-1],
					dig_s[j-1][j*pmg_pkg::DIGIT_W +: pmg_pkg::DIGIT_W],
					pmg_pkg::LEVEL_LEN[j]);
				dig_s[j]  <= dig_s[j-1];
				idx_s[j]  <= idx_s[j-1];
				last_s[j] <= last_s[j-1];
			end
		end
	end

	assign m_tvalid = vld_s[LAST_STG];
	assign m_tdata  = {4'b0, idx_s[LAST_STG], pt_s[LAST_STG].y, pt_s[LAST_STG].x};
	assign m_tlast  = last_s[LAST_STG];

endmodule

FILE: sv/peano_meander_point_generator_top.sv
// top level of the peano meander point generator
//
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid / s_tready       s_tdata[0] restart
//  m_*       out  m_tvalid / m_tready       m_tdata x, y, point_index; m_tlast last
//  cfg_*     in   cfg_valid / cfg_ready     cfg_data degree
//
//  one point per clock while m_tready is not held low; a tick passes through the queue
//  and then one pipeline stage per curve level (base cell plus seven levels) to m_tdata
//  a four-entry queue sits between the walk counter and the level pipeline
//  reset: degree 2, walk counter and point index zero, pipeline empty
//  a stall on m_tready holds the pipeline; s_tready drops only once the queue fills
module peano_meander_point_generator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,    // [0] restart, rest zero
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [55:0]                   m_tdata,    // [12:0] x_coord, [25:13] y_coord,
	                                                  // [51:26] point_index, rest zero
	output logic                          m_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pmg_pkg::DEGREE_W-1:0]  cfg_data
);

	logic [pmg_pkg::DEGREE_W-1:0] degree_q;
	logic                         q_push;
	logic                         q_not_full;
	pmg_pkg::item_t               q_in_item;
	logic                         q_valid;
	logic                         q_pop;
	pmg_pkg::item_t               q_out_item;

	// degree register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= pmg_pkg::DEGREE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			degree_q <= cfg_data;
		end
	end

	pmg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.degree     (degree_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.q_not_full (q_not_full),
		.q_push     (q_push),
		.q_item     (q_in_item)
	);

	pmg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_in_item),
		.not_full   (q_not_full),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_item   (q_out_item)
	);

	pmg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_out_item),
		.q_pop      (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the peano meander point generator
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pmg_pkg::*;

	// cycles without any transfer before the run is abandoned
	localparam int STALL_LIMIT = 3000;
	// cycles allowed after the last point for stray output (pipeline plus queue)
	localparam int TAIL_CYCLES = 20;

	// base 3x3 meander cell per low digit, digit 0 in the lowest two bits
	localparam logic [17:0] BASE_COL = {2'd2, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0};
	localparam logic [17:0] BASE_ROW = {2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0};

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [INDEX_W-1:0] idx;
		logic               is_last;
	} point_rec_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata   = '0;     // [0] restart, rest zero
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [55:0]         m_tdata;            // [12:0] x, [25:13] y, [51:26] point index
	logic                m_tlast;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [DEGREE_W-1:0] cfg_data  = '0;

	// walk state mirrored from the block
	logic [DIGIT_W-1:0]  walk_digits [MAX_DEGREE];
	logic [INDEX_W-1:0]  walk_index;
	logic [DEGREE_W-1:0] walk_degree;

	point_rec_t pending_points [$];
	point_rec_t want_pt;

	int src_idle_pct  = 0;
	int sink_idle_pct = 0;
	int mismatch_count = 0;
	int points_checked = 0;
	int degree_writes  = 0;
	int curve_ends     = 0;
	int stall_cycles   = 0;

	peano_meander_point_generator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void clear_walk();
		foreach (walk_digits[k])
			walk_digits[k] = '0;
		walk_index = '0;
	endfunction

	// point of the current walk position, then step the base-9 counter
	function automatic point_rec_t next_curve_point(input logic restart);
		point_rec_t pt;
		int unsigned levels, px, py, span, tmp;
		logic [DIGIT_W-1:0] dg;
		logic at_end, carry;
		if (walk_degree < DEGREE_MIN)
			levels = DEGREE_MIN;
		else if (walk_degree > DEGREE_MAX)
			levels = DEGREE_MAX;
		else
			levels = walk_degree;
		if (restart)
			clear_walk();

		// base cell from the lowest digit
		dg = walk_digits[0];
		px = 0;
		py = 0;
		if (dg <= TOP_DIGIT) begin
			px = BASE_COL[2 * dg +: 2];
			py = BASE_ROW[2 * dg +: 2];
		end

		// each higher digit places the sub-square of side span
		span = 1;
		for (int lvl = 1; lvl < levels; lvl++) begin
			span = span * 3;
			case (walk_digits[lvl])
				OP_SWAP: begin
					tmp = py;
					py = px;
					px = tmp;
				end
				OP_SWAP_RIGHT: begin
					tmp = py;
					py = px + span;
					px = tmp;
				end
				OP_UP2: begin
					py = py + 2 * span;
				end
				OP_RIGHT_UP2: begin
					px = px + span;
					py = py + 2 * span;
				end
				OP_RIGHT2_UP2: begin
					px = px + 2 * span;
					py = py + 2 * span;
				end
				OP_MIRROR: begin
					px = 3 * span - 1 - px;
					py = 2 * span - 1 - py;
				end
				OP_MIRROR_SWAP: begin
					tmp = py;
					py = 2 * span - 1 - px;
					px = 2 * span - 1 - tmp;
				end
				OP_FOLD_SWAP: begin
					tmp = py;
					py = span - 1 - px;
					px = 2 * span - 1 - tmp;
				end
				OP_RIGHT2: begin
					px = px + 2 * span;
				end
				default: begin
				end
			endcase
		end

		at_end = 1'b1;
		for (int k = 0; k < levels; k++)
			if (walk_digits[k] < TOP_DIGIT)
				at_end = 1'b0;

		pt.x = px[COORD_W-1:0];
		pt.y = py[COORD_W-1:0];
		pt.idx = walk_index;
		pt.is_last = at_end;

		// wrap after the final point, otherwise count up with carry
		if (at_end) begin
			clear_walk();
		end else begin
			carry = 1'b1;
			for (int k = 0; k < levels; k++) begin
				if (carry) begin
					if (walk_digits[k] < TOP_DIGIT) begin
						walk_digits[k] = walk_digits[k] + 1'b1;
						carry = 1'b0;
					end else begin
						walk_digits[k] = '0;
					end
				end
			end
			walk_index = walk_index + 1'b1;
		end
		return pt;
	endfunction

	task automatic report_mismatch(input string field, input longint unsigned want,
		input longint unsigned got);
		$display("ERROR %0t ns: point %0d %s expected %0d got %0d", $time, points_checked,
			field, want, got);
		mismatch_count++;
	endtask

	// one tick transfer on the input side, with random gaps before it
	task automatic send_tick(input logic restart);
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, restart};
		do
			@(posedge clk);
		while (!(s_tvalid && s_tready));
		pending_points.push_back(next_curve_point(restart));
	endtask

	// stop sending and wait for every outstanding point
	task automatic drain_points();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_degree(input logic [DEGREE_W-1:0] value);
		drain_points();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		walk_degree = value;
		degree_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver back-pressure
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= sink_idle_pct);

	// compare each output transfer with the oldest predicted point
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_points.size() == 0) begin
				report_mismatch("unexpected point, index", 0, m_tdata[51:26]);
			end else begin
				want_pt = pending_points.pop_front();
				if (m_tdata[12:0] !== want_pt.x)
					report_mismatch("x_coord", want_pt.x, m_tdata[12:0]);
				if (m_tdata[25:13] !== want_pt.y)
					report_mismatch("y_coord", want_pt.y, m_tdata[25:13]);
				if (m_tdata[51:26] !== want_pt.idx)
					report_mismatch("point_index", want_pt.idx, m_tdata[51:26]);
				if (m_tlast !== want_pt.is_last)
					report_mismatch("last", want_pt.is_last, m_tlast);
				if (want_pt.is_last)
					curve_ends++;
			end
			points_checked++;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d points outstanding",
					STALL_LIMIT, pending_points.size());
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// walk from reset at the reset degree
	task automatic test_reset_walk();
		repeat (4)
			send_tick(1'b0);
	endtask

	// degree 1: base cell only, last on every ninth point, restart mid-walk
	task automatic test_degree_one();
		write_degree(4'd1);
		send_tick(1'b1);
		repeat (10)
			send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
	endtask

	// degree 0 acts as 1, degrees above the maximum act as the maximum
	task automatic test_degree_bounds();
		write_degree(4'd0);
		repeat (3)
			send_tick(1'b0);
		write_degree(4'd15);
		repeat (3)
			send_tick(1'b0);
	endtask

	// one complete degree-3 curve and the wrap after it
	task automatic test_full_curve();
		write_degree(4'd3);
		send_tick(1'b1);
		repeat (729)
			send_tick(1'b0);
	endtask

	// random degrees between segments, the walk carried across degree changes
	task automatic test_random_walk(input int n_points);
		int sent, seg_len;
		logic [DEGREE_W-1:0] deg;
		sent = 0;
		while (sent < n_points) begin
			case ($urandom_range(11))
				0:       deg = 4'd1;
				1, 2:    deg = 4'd2;
				3, 4, 5: deg = 4'd3;
				6:       deg = 4'd4;
				7:       deg = 4'd5;
				8:       deg = DEGREE_MAX;
				9:       deg = 4'd0;
				10:      deg = DEGREE_W'($urandom_range(9, 15));
				default: deg = DEGREE_W'($urandom_range(6, 7));
			endcase
			write_degree(deg);
			seg_len = $urandom_range(20, 120);
			for (int i = 0; i < seg_len && sent < n_points; i++) begin
				send_tick($urandom_range(63) == 0);
				sent++;
			end
			// occasional burst of restarts
			if ($urandom_range(7) == 0)
				repeat ($urandom_range(2, 5)) begin
					send_tick(1'b1);
					sent++;
				end
		end
	endtask

	initial begin
		walk_degree = DEGREE_RESET;
		clear_walk();
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// sender idles more lightly than the receiver
		src_idle_pct = 33;
		sink_idle_pct = 49;
		test_reset_walk();
		test_degree_one();
		test_degree_bounds();
		test_full_curve();

		// receiver idles more lightly than the sender
		src_idle_pct = 49;
		sink_idle_pct = 33;
		test_random_walk(450);

		// full rate both sides
		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_random_walk(450);

		drain_points();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		@(negedge clk);

		$display("run covered %0d points, %0d degree writes and %0d curve ends,",
			points_checked, degree_writes, curve_ends);
		$display("with restarts, degree changes mid-walk and stalls on both sides");
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
